[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`endif

[sv/ufi_pkg.sv]
// ---------------------------------------------------------------------------
// ufi_pkg
// shared types, codes and defaults of the interpolating fir
// ---------------------------------------------------------------------------
package ufi_pkg;

    // default sizes
    localparam int UFI_MAX_TAPS    = 128;
    localparam int UFI_MAX_FACTOR  = 16;
    localparam int UFI_SAMPLE_BITS = 16;
    localparam int UFI_COEF_BITS   = 16;

    // fixed field widths
    localparam int KIND_W     = 2;
    localparam int COEF_IDX_W = 7;
    localparam int OUT_BITS   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int FACTOR_W   = 5;
    localparam int NTAPS_W    = 8;
    localparam int SHIFT_W    = 5;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_COEF   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TAIL   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INTERP_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_SHIFT     = 2'd2;

    // register reset values
    localparam logic [FACTOR_W-1:0] RST_INTERP_FACTOR = 5'd4;
    localparam logic [NTAPS_W-1:0]  RST_NUM_TAPS      = 8'd33;
    localparam logic [SHIFT_W-1:0]  RST_OUT_SHIFT     = 5'd15;

    // control from the sequencer to the shared mac
    typedef struct packed {
        logic clear;  // zero the accumulators
        logic issue;  // a tap/history read was addressed this cycle
    } ufi_mac_ctl_t;

endpackage

[sv/ufi_item_if.sv]
// ---------------------------------------------------------------------------
// ufi_item_if
// input channel: coefficient, sample or tail beats
// ---------------------------------------------------------------------------
interface ufi_item_if
    import ufi_pkg::*;
#(
    parameter int SAMPLE_BITS = UFI_SAMPLE_BITS,
    parameter int COEF_BITS   = UFI_COEF_BITS
);
    logic                          valid;
    logic                          ready;
    logic        [KIND_W-1:0]      kind;
    logic        [COEF_IDX_W-1:0]  coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;

    modport source (
        output valid, kind, coef_index, coef_value, sample_i, sample_q,
        input  ready
    );

    modport sink (
        input  valid, kind, coef_index, coef_value, sample_i, sample_q,
        output ready
    );
endinterface

[sv/ufi_result_if.sv]
// ---------------------------------------------------------------------------
// ufi_result_if
// output channel: one filtered complex output per beat
// ---------------------------------------------------------------------------
interface ufi_result_if
    import ufi_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] out_i;
    logic signed [OUT_BITS-1:0] out_q;
    logic                       last_of_run;
    logic                       end_of_block;

    modport source (
        output valid, out_i, out_q, last_of_run, end_of_block,
        input  ready
    );

    modport sink (
        input  valid, out_i, out_q, last_of_run, end_of_block,
        output ready
    );
endinterface

[sv/upsample_fir_interpolator_unit.sv]
// sequencing: a coefficient beat is written and the unit stays idle; a sample or tail beat
//   with n outputs runs n phases, each issuing its taps, draining the mac and finishing,
//   a phase without taps going straight to finish; outputs load at each finish
// throughput: one tap per cycle on the shared mac; a stalled result beat holds finish
// reset: registers go to factor 4, 33 taps, shift 15; history reads as zero
//   (valid bits cleared at once, no sweep); tap store holds nothing until written
// ---------------------------------------------------------------------------
// upsample_fir_interpolator_unit
// polyphase interpolating fir for complex samples, one shared mac under a
// small sequencer, output register between the mac and the result channel
// ---------------------------------------------------------------------------
module upsample_fir_interpolator_unit
    import ufi_pkg::*;
#(
    parameter int MAX_TAPS    = UFI_MAX_TAPS,
    parameter int MAX_FACTOR  = UFI_MAX_FACTOR,
    parameter int SAMPLE_BITS = UFI_SAMPLE_BITS,
    parameter int COEF_BITS   = UFI_COEF_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    ufi_item_if.sink              items,
    ufi_result_if.source          results
);

    localparam int TAW = $clog2(MAX_TAPS);               // tap / history address
    localparam int NTW = $clog2(MAX_TAPS + 1);           // tap count
    localparam int FW  = $clog2(MAX_FACTOR + 1);         // factor and phase
    localparam int KW  = $clog2(MAX_TAPS + MAX_FACTOR + 1); // running tap index

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ISSUE  = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_FINISH = 3'd3;

    // configuration registers
    logic [FACTOR_W-1:0] interp_reg;
    logic [NTAPS_W-1:0]  ntaps_reg;
    logic [SHIFT_W-1:0]  shift_reg;

    // sequencer state
    logic [2:0]     state_reg,  state_next;
    logic [FW-1:0]  phase_reg,  phase_next;
    logic [FW-1:0]  nphase_reg, nphase_next;
    logic [KW-1:0]  k_reg,      k_next;
    logic [TAW-1:0] j_reg,      j_next;
    logic [TAW-1:0] wp_reg,     wp_next;
    logic [NTW-1:0] tail_reg,   tail_next;
    logic           end_reg,    end_next;
    logic           drain_reg,  drain_next;

    // output register
    logic                       res_valid_reg;
    logic signed [OUT_BITS-1:0] res_i_reg;
    logic signed [OUT_BITS-1:0] res_q_reg;
    logic                       res_last_reg;
    logic                       res_eob_reg;

    // effective sizes and helpers
    logic [FW-1:0]  l_eff;
    logic [NTW-1:0] nt_eff;
    logic [FW-1:0]  tail_n;
    logic [TAW-1:0] wp_inc;
    logic [KW-1:0]  k_step;
    logic [TAW-1:0] hist_raddr;
    logic [TAW:0]   hist_wrap;
    logic           coef_ok;
    logic           in_acc;
    logic           res_free;
    logic           res_load;
    logic           phase_last;

    // store and mac hookup
    logic                          tap_we;
    logic                          hist_we;
    logic signed [SAMPLE_BITS-1:0] hist_wdata_i;
    logic signed [SAMPLE_BITS-1:0] hist_wdata_q;
    logic signed [COEF_BITS-1:0]   tap_rdata;
    logic signed [SAMPLE_BITS-1:0] hist_rdata_i;
    logic signed [SAMPLE_BITS-1:0] hist_rdata_q;
    logic signed [OUT_BITS-1:0]    mac_res_i;
    logic signed [OUT_BITS-1:0]    mac_res_q;
    ufi_mac_ctl_t                  mac_ctl;

    // ------------------------------------------------------------------
    // configuration port: write only while idle; the block itself does not enforce this
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg <= RST_INTERP_FACTOR;
            ntaps_reg  <= RST_NUM_TAPS;
            shift_reg  <= RST_OUT_SHIFT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INTERP_FACTOR: interp_reg <= cfg_wdata[FACTOR_W-1:0];
                REG_NUM_TAPS:      ntaps_reg  <= cfg_wdata[NTAPS_W-1:0];
                REG_OUT_SHIFT:     shift_reg  <= cfg_wdata[SHIFT_W-1:0];
                default:           ;  // unused index, write dropped
            endcase
        end
    end

    // zero acts as one, oversize clamps to the build limit
    always_comb
    begin
        if (interp_reg == '0)
        begin
            l_eff = FW'(1);
        end
        else if (32'(interp_reg) > MAX_FACTOR)
        begin
            l_eff = FW'(MAX_FACTOR);
        end
        else
        begin
            l_eff = FW'(interp_reg);
        end

        if (ntaps_reg == '0)
        begin
            nt_eff = NTW'(1);
        end
        else if (32'(ntaps_reg) > MAX_TAPS)
        begin
            nt_eff = NTW'(MAX_TAPS);
        end
        else
        begin
            nt_eff = NTW'(ntaps_reg);
        end
    end

    // tail beat emits at most one run of l outputs
    assign tail_n = (32'(tail_reg) < 32'(l_eff)) ? FW'(tail_reg) : l_eff;

    // circular history: newest sample at wp, history[j] at wp - j
    assign wp_inc = (wp_reg == TAW'(MAX_TAPS - 1)) ? '0 : wp_reg + TAW'(1);

    always_comb
    begin
        hist_wrap = {1'b0, wp_reg} + (TAW + 1)'(MAX_TAPS) - {1'b0, j_reg};
        if (wp_reg >= j_reg)
        begin
            hist_raddr = wp_reg - j_reg;
        end
        else
        begin
            hist_raddr = hist_wrap[TAW-1:0];
        end
    end

    assign k_step     = k_reg + KW'(l_eff);
    assign coef_ok    = 32'(items.coef_index) < MAX_TAPS;
    assign in_acc     = items.valid && (state_reg == S_IDLE);
    assign res_free   = !res_valid_reg || results.ready;
    assign phase_last = (phase_reg == nphase_reg - FW'(1));

    // ------------------------------------------------------------------
    // sequencer: one phase = issue its taps, drain the mac, finish
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        nphase_next  = nphase_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        wp_next      = wp_reg;
        tail_next    = tail_reg;
        end_next     = end_reg;
        drain_next   = drain_reg;
        tap_we       = 1'b0;
        hist_we      = 1'b0;
        hist_wdata_i = items.sample_i;
        hist_wdata_q = items.sample_q;
        mac_ctl      = '0;
        res_load     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (items.kind)
                        KIND_COEF:
                        begin
                            tap_we = coef_ok;
                        end
                        KIND_SAMPLE:
                        begin
                            hist_we     = 1'b1;
                            wp_next     = wp_inc;
                            nphase_next = l_eff;
                            tail_next   = nt_eff - NTW'(1);
                            end_next    = 1'b0;
                            phase_next  = '0;
                            k_next      = '0;
                            j_next      = '0;
                            mac_ctl.clear = 1'b1;
                            state_next  = S_ISSUE;
                        end
                        KIND_TAIL:
                        begin
                            // nothing left: beat is swallowed
                            if (tail_reg != '0)
                            begin
                                hist_we      = 1'b1;
                                hist_wdata_i = '0;
                                hist_wdata_q = '0;
                                wp_next      = wp_inc;
                                nphase_next  = tail_n;
                                tail_next    = tail_reg - NTW'(tail_n);
                                end_next     = (tail_reg == NTW'(tail_n));
                                phase_next   = '0;
                                k_next       = '0;
                                j_next       = '0;
                                mac_ctl.clear = 1'b1;
                                state_next   = S_ISSUE;
                            end
                        end
                        default:
                        begin
                            // unknown kind ignored
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                mac_ctl.issue = 1'b1;
                k_next        = k_step;
                j_next        = j_reg + TAW'(1);
                if (32'(k_step) >= 32'(nt_eff))
                begin
                    drain_next = 1'b1;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // drain the mac: read data to product, then product to accumulator
                if (drain_reg)
                begin
                    drain_next = 1'b0;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (res_free)
                begin
                    res_load      = 1'b1;
                    mac_ctl.clear = 1'b1;
                    if (phase_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        phase_next = phase_reg + FW'(1);
                        k_next     = KW'(phase_reg + FW'(1));
                        j_next     = '0;
                        // a phase with no taps yields zero straight away
                        if (32'(phase_reg) + 1 < 32'(nt_eff))
                        begin
                            state_next = S_ISSUE;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= '0;
            nphase_reg <= FW'(1);
            k_reg      <= '0;
            j_reg      <= '0;
            wp_reg     <= '0;
            tail_reg   <= '0;
            end_reg    <= 1'b0;
            drain_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            nphase_reg <= nphase_next;
            k_reg      <= k_next;
            j_reg      <= j_next;
            wp_reg     <= wp_next;
            tail_reg   <= tail_next;
            end_reg    <= end_next;
            drain_reg  <= drain_next;
        end
    end

    // ------------------------------------------------------------------
    // output register: mac may start the next phase while a beat waits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_i_reg    <= mac_res_i;
            res_q_reg    <= mac_res_q;
            res_last_reg <= phase_last;
            res_eob_reg  <= phase_last && end_reg;
        end
    end

    assign items.ready          = (state_reg == S_IDLE);
    assign results.valid        = res_valid_reg;
    assign results.out_i        = res_i_reg;
    assign results.out_q        = res_q_reg;
    assign results.last_of_run  = res_last_reg;
    assign results.end_of_block = res_eob_reg;

    // ------------------------------------------------------------------
    // tap and history storage
    // ------------------------------------------------------------------
    ufi_store #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .tap_we       (tap_we),
        .tap_waddr    (TAW'(items.coef_index)),
        .tap_wdata    (items.coef_value),
        .tap_raddr    (k_reg[TAW-1:0]),
        .tap_rdata    (tap_rdata),
        .hist_we      (hist_we),
        .hist_waddr   (wp_inc),
        .hist_wdata_i (hist_wdata_i),
        .hist_wdata_q (hist_wdata_q),
        .hist_raddr   (hist_raddr),
        .hist_rdata_i (hist_rdata_i),
        .hist_rdata_q (hist_rdata_q)
    );

    // ------------------------------------------------------------------
    // shared complex mac
    // ------------------------------------------------------------------
    ufi_mac #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .tap    (tap_rdata),
        .hist_i (hist_rdata_i),
        .hist_q (hist_rdata_q),
        .shift  (shift_reg),
        .res_i  (mac_res_i),
        .res_q  (mac_res_q)
    );

endmodule

[sv/ufi_store.sv]
// ---------------------------------------------------------------------------
// ufi_store
// tap memory and circular sample history with registered reads
// ---------------------------------------------------------------------------
module ufi_store
    import ufi_pkg::*;
#(
    parameter int MAX_TAPS    = UFI_MAX_TAPS,
    parameter int SAMPLE_BITS = UFI_SAMPLE_BITS,
    parameter int COEF_BITS   = UFI_COEF_BITS,
    localparam int TAW        = $clog2(MAX_TAPS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tap_we,
    input  logic        [TAW-1:0]         tap_waddr,
    input  logic signed [COEF_BITS-1:0]   tap_wdata,
    input  logic        [TAW-1:0]         tap_raddr,
    output logic signed [COEF_BITS-1:0]   tap_rdata,
    input  logic                          hist_we,
    input  logic        [TAW-1:0]         hist_waddr,
    input  logic signed [SAMPLE_BITS-1:0] hist_wdata_i,
    input  logic signed [SAMPLE_BITS-1:0] hist_wdata_q,
    input  logic        [TAW-1:0]         hist_raddr,
    output logic signed [SAMPLE_BITS-1:0] hist_rdata_i,
    output logic signed [SAMPLE_BITS-1:0] hist_rdata_q
);

    logic signed [COEF_BITS-1:0]     tap_mem [MAX_TAPS];
    logic        [2*SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
    logic        [MAX_TAPS-1:0]      hvalid_reg;

    logic signed [COEF_BITS-1:0]     tap_rd_reg;
    logic        [2*SAMPLE_BITS-1:0] hist_rd_reg;
    logic                            hv_rd_reg;

    always_ff @(posedge clk)
    begin
        if (tap_we)
        begin
            tap_mem[tap_waddr] <= tap_wdata;
        end
        tap_rd_reg <= tap_mem[tap_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= {hist_wdata_i, hist_wdata_q};
        end
        hist_rd_reg <= hist_mem[hist_raddr];
    end

    // history entries read as zero until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hvalid_reg <= '0;
            hv_rd_reg  <= 1'b0;
        end
        else
        begin
            if (hist_we)
            begin
                hvalid_reg[hist_waddr] <= 1'b1;
            end
            hv_rd_reg <= hvalid_reg[hist_raddr];
        end
    end

    assign tap_rdata    = tap_rd_reg;
    assign hist_rdata_i = hv_rd_reg ? hist_rd_reg[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    assign hist_rdata_q = hv_rd_reg ? hist_rd_reg[SAMPLE_BITS-1:0] : '0;

endmodule

[sv/ufi_mac.sv]
// ---------------------------------------------------------------------------
// ufi_mac
// shared complex multiply-accumulate with round, shift and saturate
// ---------------------------------------------------------------------------
module ufi_mac
    import ufi_pkg::*;
#(
    parameter int MAX_TAPS    = UFI_MAX_TAPS,
    parameter int SAMPLE_BITS = UFI_SAMPLE_BITS,
    parameter int COEF_BITS   = UFI_COEF_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ufi_mac_ctl_t                  ctl,
    input  logic signed [COEF_BITS-1:0]   tap,
    input  logic signed [SAMPLE_BITS-1:0] hist_i,
    input  logic signed [SAMPLE_BITS-1:0] hist_q,
    input  logic        [SHIFT_W-1:0]     shift,
    output logic signed [OUT_BITS-1:0]    res_i,
    output logic signed [OUT_BITS-1:0]    res_q
);

    localparam int PW    = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W = PW + $clog2(MAX_TAPS);
    // wide enough that the rounding bit never falls off the top
    localparam int RW    = ((ACC_W > 32) ? ACC_W : 32) + 1;
    localparam logic signed [RW-1:0] SAT_HI = RW'((1 <<< (OUT_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = -RW'(1 <<< (OUT_BITS - 1));

    logic                    v1_reg;
    logic                    pv_reg;
    logic signed [PW-1:0]    prod_i_reg;
    logic signed [PW-1:0]    prod_q_reg;
    logic signed [ACC_W-1:0] acc_i_reg;
    logic signed [ACC_W-1:0] acc_q_reg;

    function automatic logic signed [OUT_BITS-1:0] finish(
        input logic signed [ACC_W-1:0] acc,
        input logic [SHIFT_W-1:0]      s
    );
        logic signed [RW-1:0] ext;
        logic signed [RW-1:0] rnd;
        logic signed [RW-1:0] shd;
        logic signed [OUT_BITS-1:0] r;
        ext = RW'(acc);
        if (s == '0)
        begin
            rnd = ext;
        end
        else
        begin
            rnd = ext + (RW'(1) << (s - SHIFT_W'(1)));
        end
        shd = rnd >>> s;
        if (shd > SAT_HI)
        begin
            r = SAT_HI[OUT_BITS-1:0];
        end
        else if (shd < SAT_LO)
        begin
            r = SAT_LO[OUT_BITS-1:0];
        end
        else
        begin
            r = shd[OUT_BITS-1:0];
        end
        return r;
    endfunction

    // memory data arrives in the cycle after issue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.issue;
            pv_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_i_reg <= tap * hist_i;
            prod_q_reg <= tap * hist_q;
        end
        if (ctl.clear)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (pv_reg)
        begin
            acc_i_reg <= acc_i_reg + ACC_W'(prod_i_reg);
            acc_q_reg <= acc_q_reg + ACC_W'(prod_q_reg);
        end
    end

    assign res_i = finish(acc_i_reg, shift);
    assign res_q = finish(acc_q_reg, shift);

endmodule

[sv/ufi_checker.sv]
// ---------------------------------------------------------------------------
// ufi_checker
// port-level checks of the interpolating fir, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ufi_checker
    import ufi_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic [KIND_W-1:0] in_kind,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_last,
    input logic              out_eob
);

    logic in_take;

    assign in_take = in_valid && in_ready;

    // a waiting output beat is not withdrawn
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // the block end always closes a run
    `ASSERT_IMPLIES(a_eob_last, clk, rst_n, out_valid && out_eob, out_last)

    // a sample beat always starts a run that holds off the input
    `ASSERT_NEXT(a_busy_after_sample, clk, rst_n, in_take && in_kind == KIND_SAMPLE, !in_ready)

    // a coefficient write finishes in its own cycle
    `ASSERT_NEXT(a_coef_single, clk, rst_n, in_take && in_kind == KIND_COEF, in_ready)

endmodule

bind upsample_fir_interpolator_unit ufi_checker u_ufi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_kind   (items.kind),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_last  (results.last_of_run),
    .out_eob   (results.end_of_block)
);
